// ===== rtl/lph_pkg.sv =====
// shared types and constants for the linear probing hash table
package lph_pkg;

    localparam int unsigned KEY_W       = 31;
    localparam int unsigned DATA_W      = 32;
    localparam int unsigned OP_W        = 2;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned SLOT_W      = 4;
    localparam int unsigned COUNT_W     = 5;
    localparam int unsigned IN_TDATA_W  = 72;
    localparam int unsigned OUT_TDATA_W = 16;

    typedef logic [OP_W-1:0]     t_op;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_op OP_INSERT = 2'd0;
    localparam t_op OP_SEARCH = 2'd1;
    localparam t_op OP_DELETE = 2'd2;
    localparam t_op OP_NONE   = 2'd3;

    localparam t_status STAT_OK      = 2'd0;
    localparam t_status STAT_FULL    = 2'd1;
    localparam t_status STAT_MISSING = 2'd2;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic              start;
        logic              flush;
        logic              en;
        t_op               op;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] payload;
    } t_probe_cmd;

endpackage

// ===== rtl/linear_probe_hash_table_top.sv =====
// top level of the linear probing hash table: sequencer and ring of slot cells
//
// Requests enter on the s channel (i_s_tdata: opcode, key, payload) and one
// result leaves on the m channel for each request (o_m_tdata: status, slot,
// entry count). One request is worked at a time; o_s_tready is high only
// while the block is idle.
// The table is a ring of TABLE_SLOTS cells. A probe token starts at the home
// slot and moves one cell a cycle while the output register is free; the cell
// holding it compares its key or checks for an empty slot. A search, delete
// or insert into a table that is not full probes from 1 to TABLE_SLOTS slots;
// a full-table insert or unused opcode probes no slot. For a power-of-two
// table the low key bits give the home slot as the request is taken; other
// table sizes reduce the key to its home slot by reciprocal multiplication
// in the states ST_MOD and ST_FOLD. The next request can be taken once the
// result is registered.
// When the receiver stalls, the result is held and the probe walk freezes
// until the output register is free.
// Reset empties the table (valid bits and count cleared).
module linear_probe_hash_table_top #(
    parameter int unsigned TABLE_SLOTS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // opcode [1:0], key [32:2], payload [64:33], zero [71:65]
    input  logic [lph_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // status [1:0], slot [5:2], entry_count [10:6], zero [15:11]
    output logic [lph_pkg::OUT_TDATA_W-1:0] o_m_tdata
);
    import lph_pkg::*;

    localparam int unsigned SW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

    t_probe_cmd             cmd;
    logic [SW-1:0]          home;
    logic [TABLE_SLOTS-1:0] w_tok;
    logic [TABLE_SLOTS-1:0] w_hit;

    lph_ctrl #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .SW          (SW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_cmd      (cmd),
        .o_home     (home),
        .i_hit_any  (|w_hit)
    );

    for (genvar g = 0; g < TABLE_SLOTS; g++) begin : g_cell
        lph_cell #(
            .IDX (g),
            .SW  (SW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cmd),
            .i_home  (home),
            .i_tok   (w_tok[(g + TABLE_SLOTS - 1) % TABLE_SLOTS]),
            .o_tok   (w_tok[g]),
            .o_hit   (w_hit[g])
        );
    end

endmodule

// ===== rtl/lph_cell.sv =====
// one table slot: key, data, valid bit and the probe token passed along the ring
module lph_cell #(
    parameter int unsigned IDX = 0,
    parameter int unsigned SW  = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lph_pkg::t_probe_cmd i_cmd,
    input  logic [SW-1:0]      i_home,
    input  logic               i_tok,
    output logic               o_tok,
    output logic               o_hit
);
    import lph_pkg::*;

    logic              r_valid;
    logic [KEY_W-1:0]  r_key;
    logic [DATA_W-1:0] r_data;
    logic              r_tok;
    logic              match;

    always_comb begin
        unique case (i_cmd.op)
            OP_INSERT: match = !r_valid;
            OP_SEARCH,
            OP_DELETE: match = r_valid && (r_key == i_cmd.key);
            default:   match = 1'b0;
        endcase
    end

    assign o_hit = r_tok && match && i_cmd.en;
    assign o_tok = r_tok && !match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_tok <= (i_home == SW'(IDX));
            end else if (i_cmd.flush) begin
                r_tok <= 1'b0;
            end else if (i_cmd.en) begin
                r_tok <= i_tok;
            end
            if (o_hit && (i_cmd.op != OP_SEARCH)) begin
                r_valid <= (i_cmd.op == OP_INSERT);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_hit && (i_cmd.op == OP_INSERT)) begin
            r_key  <= i_cmd.key;
            r_data <= i_cmd.payload;
        end
    end

endmodule

// ===== rtl/lph_ctrl.sv =====
// request sequencer: home slot, probe walk, occupancy count and result register
module lph_ctrl #(
    parameter int unsigned TABLE_SLOTS = 16,
    parameter int unsigned SW          = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [lph_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [lph_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    output lph_pkg::t_probe_cmd              o_cmd,
    output logic [SW-1:0]                    o_home,
    input  logic                             i_hit_any
);
    import lph_pkg::*;

    localparam int unsigned CW      = $clog2(TABLE_SLOTS + 1);
    localparam bit          POW2    = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);
    localparam int unsigned RECIP_W = 32;
    localparam int unsigned PROD_W  = KEY_W + RECIP_W;
    localparam int unsigned SHIFT   = RECIP_W + SW - 1;
    localparam logic [63:0] RECIP_FULL = (64'd1 << SHIFT) / 64'(TABLE_SLOTS);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MOD  = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_FOLD = 2'd3;

    logic [1:0]           r_state, n_state;
    t_op                  r_op;
    logic [KEY_W-1:0]     r_key;
    logic [DATA_W-1:0]    r_payload;
    logic                 r_go;
    logic [PROD_W-1:0]    r_prod;
    logic [SW-1:0]        r_ptr, n_ptr;
    logic [SW-1:0]        r_step;
    logic [CW-1:0]        r_count, n_count;
    logic                 r_out_valid;
    t_status              r_out_status, n_out_status;
    logic [SLOT_W-1:0]    r_out_slot, n_out_slot;
    logic [COUNT_W-1:0]   r_out_count;

    t_op               in_op;
    logic [KEY_W-1:0]  in_key;
    logic [DATA_W-1:0] in_payload;
    logic              accept;
    logic              go_in;
    logic              out_free;
    logic [SW:0]       q_lo;
    logic [SW:0]       mod_t;
    logic [SW:0]       mod_r;
    logic              start;
    logic              finish;
    logic [SW-1:0]     home;

    assign in_op      = i_s_tdata[1:0];
    assign in_key     = i_s_tdata[32:2];
    assign in_payload = i_s_tdata[64:33];

    assign o_s_tready = (r_state == ST_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;

    always_comb begin
        unique case (in_op)
            OP_INSERT: go_in = (r_count != CW'(TABLE_SLOTS));
            OP_SEARCH,
            OP_DELETE: go_in = 1'b1;
            default:   go_in = 1'b0;
        endcase
    end

    // reciprocal quotient estimate, at most one short, then one correction step
    assign q_lo  = r_prod[SHIFT +: (SW + 1)];
    assign mod_t = r_key[SW:0] - q_lo * (SW + 1)'(TABLE_SLOTS);
    assign mod_r = (mod_t >= (SW + 1)'(TABLE_SLOTS)) ? (mod_t - (SW + 1)'(TABLE_SLOTS)) : mod_t;

    always_comb begin
        n_state = r_state;
        start   = 1'b0;
        home    = '0;
        finish  = 1'b0;
        n_ptr   = (r_ptr == SW'(TABLE_SLOTS - 1)) ? '0 : r_ptr + SW'(1);
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (POW2) begin
                        start   = go_in;
                        home    = in_key[SW-1:0];
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_MOD;
                    end
                end
            end
            ST_MOD: begin
                n_state = ST_FOLD;
            end
            ST_FOLD: begin
                start   = r_go;
                home    = mod_r[SW-1:0];
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (out_free) begin
                    finish = !r_go || i_hit_any || (r_step == SW'(TABLE_SLOTS - 1));
                    if (finish) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_count      = r_count;
        n_out_status = STAT_OK;
        n_out_slot   = '0;
        if (!r_go) begin
            n_out_status = (r_op == OP_INSERT) ? STAT_FULL : STAT_OK;
        end else if (i_hit_any) begin
            n_out_slot = SLOT_W'(r_ptr);
            if (r_op == OP_INSERT) begin
                n_count = r_count + CW'(1);
            end else if (r_op == OP_DELETE) begin
                n_count = r_count - CW'(1);
            end
        end else begin
            n_out_status = (r_op == OP_INSERT) ? STAT_FULL : STAT_MISSING;
        end
    end

    assign o_cmd.start   = start;
    assign o_cmd.flush   = finish;
    assign o_cmd.en      = (r_state == ST_SCAN) && out_free;
    assign o_cmd.op      = r_op;
    assign o_cmd.key     = r_key;
    assign o_cmd.payload = r_payload;
    assign o_home        = home;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_go        <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_go <= go_in;
            end
            if (finish) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op      <= in_op;
            r_key     <= in_key;
            r_payload <= in_payload;
        end
        if (r_state == ST_MOD) begin
            r_prod <= PROD_W'(r_key) * PROD_W'(RECIP);
        end
        if ((r_state == ST_IDLE && accept && POW2) || (r_state == ST_FOLD)) begin
            r_ptr  <= home;
            r_step <= '0;
        end else if (r_state == ST_SCAN && out_free && !finish) begin
            r_ptr  <= n_ptr;
            r_step <= r_step + SW'(1);
        end
        if (finish) begin
            r_out_status <= n_out_status;
            r_out_slot   <= n_out_slot;
            r_out_count  <= COUNT_W'(n_count);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_out_count, r_out_slot, r_out_status};

endmodule

// ===== rtl/lph_chk.sv =====
// port-level checks for the linear probing hash table
module lph_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic [lph_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [lph_pkg::OUT_TDATA_W-1:0] o_m_tdata
);
    import lph_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result dropped or changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("second request taken while one is in work");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[1:0] != 2'd3)
        else $error("unused status code");

    a_slot_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[1:0] != STAT_OK) |-> o_m_tdata[5:2] == '0)
        else $error("slot nonzero on a failed request");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && o_s_tready)
        else $error("block not idle after reset");

endmodule

bind linear_probe_hash_table_top lph_chk u_lph_chk (.*);

// ===== verif/linear_probe_hash_table_top_tb.sv =====
// testbench for the linear probing hash table: shadow table, directed and random requests
`timescale 1ns / 100ps

typedef struct {
    lph_pkg::t_op     op;
    logic [30:0]      key;
    lph_pkg::t_status status;
    logic [3:0]       slot;
    logic [4:0]       count;
} t_lph_outcome;

class lph_table_shadow #(int unsigned SLOTS = 16);
    logic [30:0]  slot_key [SLOTS];
    bit           slot_used [SLOTS];
    int unsigned  entries;
    int unsigned  errors;
    t_lph_outcome outstanding [$];

    function new();
        entries = 0;
        errors  = 0;
        foreach (slot_used[i]) slot_used[i] = 1'b0;
    endfunction

    function int unsigned pending();
        return outstanding.size();
    endfunction

    function void note_mismatch(string what);
        errors++;
        if (errors <= 10) $display("%s", what);
    endfunction

    // applies one request to the shadow table and queues its result
    function void note_request(lph_pkg::t_op op, logic [30:0] key);
        int unsigned  home;
        int unsigned  s;
        bit           hit;
        t_lph_outcome outcome;
        home           = key % SLOTS;
        hit            = 1'b0;
        outcome.op     = op;
        outcome.key    = key;
        outcome.status = lph_pkg::STAT_OK;
        outcome.slot   = '0;
        case (op)
            lph_pkg::OP_INSERT: begin
                if (entries < SLOTS) begin
                    for (int n = 0; n < SLOTS && !hit; n++) begin
                        s = (home + n) % SLOTS;
                        if (!slot_used[s]) begin
                            slot_used[s] = 1'b1;
                            slot_key[s]  = key;
                            entries++;
                            outcome.slot = s[3:0];
                            hit          = 1'b1;
                        end
                    end
                end
                if (!hit) outcome.status = lph_pkg::STAT_FULL;
            end
            lph_pkg::OP_SEARCH, lph_pkg::OP_DELETE: begin
                for (int n = 0; n < SLOTS && !hit; n++) begin
                    s = (home + n) % SLOTS;
                    if (slot_used[s] && slot_key[s] == key) begin
                        hit          = 1'b1;
                        outcome.slot = s[3:0];
                        if (op == lph_pkg::OP_DELETE) begin
                            slot_used[s] = 1'b0;
                            entries--;
                        end
                    end
                end
                if (!hit) outcome.status = lph_pkg::STAT_MISSING;
            end
            default: ;
        endcase
        outcome.count = entries[4:0];
        outstanding.push_back(outcome);
    endfunction

    function void check_result(logic [15:0] word);
        t_lph_outcome     want;
        lph_pkg::t_status got_status;
        logic [3:0]       got_slot;
        logic [4:0]       got_count;
        got_status = word[1:0];
        got_slot   = word[5:2];
        got_count  = word[10:6];
        if (outstanding.size() == 0) begin
            note_mismatch($sformatf("unexpected result: status %0d slot %0d count %0d",
                got_status, got_slot, got_count));
            return;
        end
        want = outstanding.pop_front();
        if (got_status !== want.status || got_slot !== want.slot
                || got_count !== want.count) begin
            note_mismatch($sformatf(
                "op %0d key 0x%08h: expected status %0d slot %0d count %0d, got %0d %0d %0d",
                want.op, want.key, want.status, want.slot, want.count,
                got_status, got_slot, got_count));
        end
    endfunction
endclass

module linear_probe_hash_table_top_tb;
    import lph_pkg::*;

    localparam int unsigned SLOTS = 16;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    logic [30:0] key_pool [24];

    lph_table_shadow #(SLOTS) shadow;

    linear_probe_hash_table_top #(
        .TABLE_SLOTS (SLOTS)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic send_request(t_op op, logic [30:0] key, logic [31:0] payload);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, payload, key, op};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        shadow.note_request(op, key);
    endtask

    function automatic logic [30:0] pick_key();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 65) return key_pool[$urandom_range(23)];
        if (r < 80) return 31'($urandom_range(63));
        return 31'($urandom);
    endfunction

    // lean towards inserts on a sparse table and deletes on a crowded one
    function automatic t_op pick_op();
        int unsigned r;
        int unsigned ins_pct;
        r       = $urandom_range(99);
        ins_pct = (shadow.entries < 6) ? 60 : (shadow.entries > 13) ? 25 : 40;
        if (r < ins_pct) return OP_INSERT;
        if (r < ins_pct + (97 - ins_pct) / 2) return OP_SEARCH;
        if (r < 97) return OP_DELETE;
        return OP_NONE;
    endfunction

    initial begin
        @(posedge clk iff rst_n);
        forever begin
            @(posedge clk);
            if (m_tvalid && m_tready) shadow.check_result(m_tdata);
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        logic [30:0] fill_key;
        shadow = new();
        foreach (key_pool[i]) begin
            key_pool[i] = (i < 12) ? 31'($urandom_range(47)) : 31'($urandom);
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 12;
        recv_idle_pct = 82;
        send_request(OP_INSERT, 31'd0, 32'h7FFF_FFFF);
        send_request(OP_INSERT, 31'h7FFF_FFFF, 32'h8000_0000);
        send_request(OP_INSERT, 31'd17, 32'h0000_0000);
        send_request(OP_INSERT, 31'd33, 32'hFFFF_FFFF);
        send_request(OP_SEARCH, 31'h7FFF_FFFF, 32'h0);
        send_request(OP_DELETE, 31'd17, 32'h0);
        // home slot now empty, key sits one further on
        send_request(OP_SEARCH, 31'd33, 32'h0);
        send_request(OP_DELETE, 31'd33, 32'h0);
        send_request(OP_SEARCH, 31'd33, 32'h0);
        send_request(OP_DELETE, 31'd33, 32'h0);
        send_request(OP_NONE, 31'd5, 32'hFFFF_FFFF);
        fill_key = 31'd100;
        while (shadow.entries < SLOTS) begin
            send_request(OP_INSERT, fill_key, $urandom);
            fill_key = fill_key + 31'd7;
        end
        send_request(OP_INSERT, 31'd2, 32'h1234_5678);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 12 : (phase == 1) ? 82 : 0;
            recv_idle_pct = (phase == 0) ? 82 : (phase == 1) ? 12 : 0;
            repeat (633) send_request(pick_op(), pick_key(), $urandom);
        end
        s_tvalid <= 1'b0;

        while (shadow.pending() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (shadow.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
